### rtl/rrsu_pkg.sv
// ----------------------------------------------------------------------------
// rrsu_pkg: shared types and constants
// Widths, mode codes, register indexes and the result record used by the
// run reduce and scan unit.
// ----------------------------------------------------------------------------
package rrsu_pkg;

	localparam int SAMPLE_W = 32;
	localparam int VALUE_W  = 64;
	localparam int POS_W    = 16;
	localparam int MODE_W   = 4;
	localparam int ORIGIN_W = 16;
	localparam int ARG_W    = POS_W + 2;

	// longest run whose index is still counted; later elements share the cap
	localparam int RUN_LENGTH_MAX = 65536;
	localparam int POS_CAP_INT    = ((RUN_LENGTH_MAX - 1) < ((1 << POS_W) - 1)) ?
		(RUN_LENGTH_MAX - 1) : ((1 << POS_W) - 1);
	localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);

	// result queue between front and back; depth must be a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic REG_MODE   = 1'b0;
	localparam logic REG_ORIGIN = 1'b1;
	localparam logic [MODE_W-1:0]   MODE_RESET   = '0;
	localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = ORIGIN_W'(1);

	typedef enum logic [MODE_W-1:0] {
		MODE_MIN    = 4'd0,
		MODE_MAX    = 4'd1,
		MODE_ARGMIN = 4'd2,
		MODE_ARGMAX = 4'd3,
		MODE_PTP    = 4'd4,
		MODE_SUM    = 4'd5,
		MODE_PSUM   = 4'd6,
		MODE_DIF    = 4'd7,
		MODE_CUM    = 4'd8,
		MODE_ZCEN   = 4'd9,
		MODE_PCEN   = 4'd10,
		MODE_UNCP   = 4'd11
	} mode_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [ORIGIN_W-1:0] origin;
	} cfg_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               half;
		logic               length_error;
		logic               last_result;
	} result_t;

	// results written into the queue in one cycle (count is 0, 1 or 2)
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} head_t;

	function automatic result_t make_result(logic [VALUE_W-1:0] v, logic h, logic e, logic l);
		result_t r;
		r.value        = v;
		r.half         = h;
		r.length_error = e;
		r.last_result  = l;
		return r;
	endfunction

endpackage

### rtl/rrsu_if.sv
// ----------------------------------------------------------------------------
// rrsu stream interfaces
// Sample channel into the unit and result channel out of it, valid/ready.
// ----------------------------------------------------------------------------
interface rrsu_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rrsu_pkg::SAMPLE_W-1:0] sample;
	logic                                 last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface rrsu_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [rrsu_pkg::VALUE_W-1:0] value;
	logic                                half;
	logic                                length_error;
	logic                                last_result;

	modport source (output valid, output value, output half, output length_error,
		output last_result, input ready);
	modport sink   (input valid, input value, input half, input length_error,
		input last_result, output ready);
endinterface

### rtl/run_reduce_and_scan_unit_top.sv
// ----------------------------------------------------------------------------
// run_reduce_and_scan_unit_top: run reduction and prefix scan
// Channel   Dir  Handshake      Payload
// samples   in   valid/ready    sample[31:0] signed, last_sample
// results   out  valid/ready    value[63:0] signed, half, length_error,
//                               last_result
// apb       in   psel/penable   paddr[2:0], pwdata/prdata[31:0]; mode @0,
//                               index_origin @4
//
// One sample is taken per cycle while the result queue has room; its results
// pass through the result queue into the output register. The output register
// sends one result per cycle while results.ready is high, so the two-result
// items (end of cum and pcen runs) leave as two results in turn. samples.ready
// drops while the four-entry result queue has under two free entries. Reset
// clears all run state at once; no clearing pass.
module run_reduce_and_scan_unit_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rrsu_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rrsu_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rrsu_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	rrsu_in_if.sink                         samples,
	rrsu_out_if.source                      results
);
	import rrsu_pkg::*;

	cfg_t  cfg_q;
	push_t push;
	head_t head;
	logic  room, pop, wr_en;

	// register file
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_RESET;
			cfg_q.origin <= ORIGIN_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_MODE:   cfg_q.mode   <= pwdata[MODE_W-1:0];
				REG_ORIGIN: cfg_q.origin <= pwdata[ORIGIN_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MODE:   prdata = APB_DATA_W'(cfg_q.mode);
			REG_ORIGIN: prdata = APB_DATA_W'(cfg_q.origin);
			default:    prdata = '0;
		endcase
	end

	rrsu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.room    (room),
		.samples (samples),
		.push    (push)
	);

	rrsu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.room   (room),
		.head   (head)
	);

	rrsu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

endmodule

### rtl/rrsu_front.sv
// ----------------------------------------------------------------------------
// rrsu_front: sample intake and run tracking
// Accepts one sample a cycle while room is high, updates the running trackers
// and forms the zero, one or two result records that the sample causes.
// ----------------------------------------------------------------------------
module rrsu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  rrsu_pkg::cfg_t  cfg,
	input  logic            room,
	rrsu_in_if.sink         samples,
	output rrsu_pkg::push_t push
);
	import rrsu_pkg::*;

	logic [POS_W-1:0]    pos_q;
	logic [VALUE_W-1:0]  acc_q;
	logic [SAMPLE_W-1:0] prev_q;
	logic [VALUE_W-1:0]  pending_q;
	logic [SAMPLE_W-1:0] lo_q, hi_q;
	logic [POS_W-1:0]    lo_pos_q, hi_pos_q;

	logic                accept, first, last;
	logic [SAMPLE_W-1:0] x;
	logic [VALUE_W-1:0]  x64, acc_after, pending_next;
	logic [SAMPLE_W-1:0] lo_n, hi_n;
	logic [POS_W-1:0]    lo_pos_n, hi_pos_n, pos_next;
	logic [SAMPLE_W:0]   diff, mean_sum, ptp;
	logic [VALUE_W-1:0]  diff64, mean64, ptp64, lo64, hi64, arg_lo64, arg_hi64;
	logic signed [ARG_W-1:0] arg_lo, arg_hi;
	logic [1:0]          n;
	result_t             r0, r1;

	assign samples.ready = room;
	assign accept        = samples.valid && room;
	assign x             = samples.sample;
	assign last          = samples.last_sample;
	assign first         = (pos_q == '0);
	assign x64           = {{(VALUE_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
	assign acc_after     = acc_q + x64;

	// track extremes; a new maximum takes precedence over a new minimum
	always_comb begin
		lo_n     = lo_q;
		hi_n     = hi_q;
		lo_pos_n = lo_pos_q;
		hi_pos_n = hi_pos_q;
		if (first) begin
			lo_n     = x;
			hi_n     = x;
			lo_pos_n = '0;
			hi_pos_n = '0;
		end else if ($signed(x) > $signed(hi_q)) begin
			hi_n     = x;
			hi_pos_n = pos_q;
		end else if ($signed(x) < $signed(lo_q)) begin
			lo_n     = x;
			lo_pos_n = pos_q;
		end
	end

	// element arithmetic, all at 33 bits before extension
	assign diff     = {x[SAMPLE_W-1], x} - {prev_q[SAMPLE_W-1], prev_q};
	assign mean_sum = {x[SAMPLE_W-1], x} + {prev_q[SAMPLE_W-1], prev_q};
	assign ptp      = (lo_pos_n < hi_pos_n) ?
		({hi_n[SAMPLE_W-1], hi_n} - {lo_n[SAMPLE_W-1], lo_n}) :
		({lo_n[SAMPLE_W-1], lo_n} - {hi_n[SAMPLE_W-1], hi_n});
	assign diff64 = {{(VALUE_W-SAMPLE_W-1){diff[SAMPLE_W]}}, diff};
	assign ptp64  = {{(VALUE_W-SAMPLE_W-1){ptp[SAMPLE_W]}}, ptp};
	// floor of the pair mean; the dropped bit is the half
	assign mean64 = {{(VALUE_W-SAMPLE_W){mean_sum[SAMPLE_W]}}, mean_sum[SAMPLE_W:1]};
	assign lo64   = {{(VALUE_W-SAMPLE_W){lo_n[SAMPLE_W-1]}}, lo_n};
	assign hi64   = {{(VALUE_W-SAMPLE_W){hi_n[SAMPLE_W-1]}}, hi_n};

	assign arg_lo   = ARG_W'($signed({1'b0, lo_pos_n})) + ARG_W'($signed(cfg.origin));
	assign arg_hi   = ARG_W'($signed({1'b0, hi_pos_n})) + ARG_W'($signed(cfg.origin));
	assign arg_lo64 = VALUE_W'(arg_lo);
	assign arg_hi64 = VALUE_W'(arg_hi);

	assign pending_next = first ? x64 : ((x64 << 1) - pending_q);
	assign pos_next     = last ? '0 : ((pos_q < POS_CAP) ? pos_q + 1'b1 : pos_q);

	// classify the sample into result records
	always_comb begin
		n  = 2'd0;
		r0 = make_result('0, 1'b0, 1'b0, 1'b0);
		r1 = make_result(acc_after, 1'b0, 1'b0, 1'b1);
		case (cfg.mode)
			MODE_MIN: begin
				n  = last ? 2'd1 : 2'd0;
				r0 = make_result(lo64, 1'b0, 1'b0, 1'b1);
			end
			MODE_MAX: begin
				n  = last ? 2'd1 : 2'd0;
				r0 = make_result(hi64, 1'b0, 1'b0, 1'b1);
			end
			MODE_ARGMIN: begin
				n  = last ? 2'd1 : 2'd0;
				r0 = make_result(arg_lo64, 1'b0, 1'b0, 1'b1);
			end
			MODE_ARGMAX: begin
				n  = last ? 2'd1 : 2'd0;
				r0 = make_result(arg_hi64, 1'b0, 1'b0, 1'b1);
			end
			MODE_PTP: begin
				n  = last ? 2'd1 : 2'd0;
				r0 = make_result(ptp64, 1'b0, 1'b0, 1'b1);
			end
			MODE_SUM: begin
				n  = last ? 2'd1 : 2'd0;
				r0 = make_result(acc_after, 1'b0, 1'b0, 1'b1);
			end
			MODE_PSUM: begin
				n  = 2'd1;
				r0 = make_result(acc_after, 1'b0, 1'b0, last);
			end
			MODE_DIF: begin
				n  = (first && !last) ? 2'd0 : 2'd1;
				r0 = first ? make_result('0, 1'b0, 1'b1, 1'b1) :
					make_result(diff64, 1'b0, 1'b0, last);
			end
			MODE_CUM: begin
				n  = last ? 2'd2 : 2'd1;
				r0 = make_result(acc_q, 1'b0, 1'b0, 1'b0);
			end
			MODE_ZCEN: begin
				n  = (first && !last) ? 2'd0 : 2'd1;
				r0 = first ? make_result('0, 1'b0, 1'b1, 1'b1) :
					make_result(mean64, mean_sum[0], 1'b0, last);
			end
			MODE_PCEN: begin
				n  = last ? 2'd2 : 2'd1;
				r0 = first ? make_result(x64, 1'b0, 1'b0, 1'b0) :
					make_result(mean64, mean_sum[0], 1'b0, 1'b0);
				r1 = make_result(x64, 1'b0, 1'b0, 1'b1);
			end
			MODE_UNCP: begin
				n  = (first && !last) ? 2'd0 : 2'd1;
				r0 = first ? make_result('0, 1'b0, 1'b1, 1'b1) :
					make_result(pending_q, 1'b0, 1'b0, last);
			end
			default: begin
				n = 2'd0;
			end
		endcase
	end

	always_comb begin
		push.count = accept ? n : 2'd0;
		push.r0    = r0;
		push.r1    = r1;
	end

	// advance run state on each accepted item; clear sums at run end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			acc_q     <= '0;
			prev_q    <= '0;
			pending_q <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			lo_pos_q  <= '0;
			hi_pos_q  <= '0;
		end else if (accept) begin
			pos_q     <= pos_next;
			acc_q     <= last ? '0 : acc_after;
			pending_q <= last ? '0 : pending_next;
			prev_q    <= x;
			lo_q      <= lo_n;
			hi_q      <= hi_n;
			lo_pos_q  <= lo_pos_n;
			hi_pos_q  <= hi_pos_n;
		end
	end

endmodule

### rtl/rrsu_queue.sv
// ----------------------------------------------------------------------------
// rrsu_queue: result queue
// Short queue of result records; takes up to two a cycle, gives one.
// ----------------------------------------------------------------------------
module rrsu_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  rrsu_pkg::push_t push,
	input  logic            pop,
	output logic            room,
	output rrsu_pkg::head_t head
);
	import rrsu_pkg::*;

	result_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_next;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	// room for the worst case of two records
	assign room        = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign head.valid  = (count_q != '0);
	assign head.res    = entry_q[rd_ptr_q];
	assign do_pop      = pop && head.valid;
	assign wr_ptr_next = wr_ptr_q + 1'b1;

	// store records at the tail
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_next] <= push.r1;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(do_pop);
		end
	end

endmodule

### rtl/rrsu_back.sv
// ----------------------------------------------------------------------------
// rrsu_back: result output stage
// Drains the queue into the output register, one item a cycle unless stalled.
// ----------------------------------------------------------------------------
module rrsu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rrsu_pkg::head_t head,
	output logic            pop,
	rrsu_out_if.source      results
);
	import rrsu_pkg::*;

	logic    valid_q;
	result_t res_q;

	// refill whenever the register is empty or being taken
	assign pop = head.valid && (!valid_q || results.ready);

	assign results.valid        = valid_q;
	assign results.value        = res_q.value;
	assign results.half         = res_q.half;
	assign results.length_error = res_q.length_error;
	assign results.last_result  = res_q.last_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= head.res;
		end
	end

endmodule

### rtl/rrsu_checker.sv
// ----------------------------------------------------------------------------
// rrsu_checker: port-level checks
// Watches the top-level ports of the unit; attached by bind.
// ----------------------------------------------------------------------------
module rrsu_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [rrsu_pkg::APB_ADDR_W-1:0] paddr,
	input logic [rrsu_pkg::APB_DATA_W-1:0] pwdata,
	input logic [rrsu_pkg::APB_DATA_W-1:0] prdata,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [rrsu_pkg::VALUE_W-1:0]    out_value,
	input logic                            out_last
);
	import rrsu_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
		else $error("result changed while stalled");

	// a fresh result is traced back to an accepted item
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result appeared without an accepted item");

	// a written mode reads back
	a_mode_rb: assert property (@(posedge clk) disable iff (!arst_n)
		$past(psel && penable && pwrite && (paddr[2] == REG_MODE)) &&
		psel && !pwrite && (paddr[2] == REG_MODE)
		|-> prdata[MODE_W-1:0] == $past(pwdata[MODE_W-1:0]))
		else $error("mode readback mismatch");

endmodule

bind run_reduce_and_scan_unit_top rrsu_checker u_rrsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_value (results.value),
	.out_last  (results.last_result)
);

### sim/tb_run_reduce_and_scan_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_run_reduce_and_scan_unit_top: self-checking bench for the reduce/scan unit
// Drives signed samples in runs under every mode and a range of index origins,
// predicts each result in the bench and checks the result stream in order.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_run_reduce_and_scan_unit_top;

	import rrsu_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int ITEMS_RANDOM   = 1350;
	localparam int SETTLE_CYCLES  = 8;

	localparam logic [MODE_W-1:0]          MODE_UNKNOWN = 4'hF;
	localparam logic signed [SAMPLE_W-1:0] S_MAX        = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN        = 32'sh8000_0000;
	localparam logic signed [ORIGIN_W-1:0] ORIGIN_LOW   = 16'sh8000;
	localparam logic signed [ORIGIN_W-1:0] ORIGIN_HIGH  = 16'sh7FFF;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} sample_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	rrsu_in_if  samples ();
	rrsu_out_if results ();

	run_reduce_and_scan_unit_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.samples (samples),
		.results (results)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// bench copy of the configuration
	logic [MODE_W-1:0]          cfg_mode;
	logic signed [ORIGIN_W-1:0] cfg_origin;

	// bench copy of the run state
	logic [POS_W-1:0]           run_pos;
	logic [VALUE_W-1:0]         run_sum;
	logic signed [SAMPLE_W-1:0] prev_sample;
	logic [VALUE_W-1:0]         uncentre_val;
	logic signed [SAMPLE_W-1:0] low_val;
	logic signed [SAMPLE_W-1:0] high_val;
	logic [POS_W-1:0]           low_pos;
	logic [POS_W-1:0]           high_pos;

	sample_item_t pending_items[$];
	result_t      expected_results[$];

	logic        steady;
	int unsigned send_gap;
	int unsigned stall_left;
	int unsigned stall_cycles;
	int unsigned mismatches;
	int unsigned samples_taken;
	int unsigned results_checked;
	int unsigned runs_closed;
	int unsigned settings_used;
	int unsigned length_errors;
	logic [15:0] modes_seen;

	// short gaps mostly, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// sample mix: full range, small values for ties, and the extremes
	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int unsigned                r;
		logic signed [SAMPLE_W-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 40)
			v = $urandom;
		else if (r < 75)
			v = 32'($urandom_range(0, 32)) - 32'sd16;
		else if (r < 82)
			v = S_MAX;
		else if (r < 89)
			v = S_MIN;
		else if (r < 94)
			v = '0;
		else
			v = '1;
		return v;
	endfunction

	function automatic void add_expect(logic [VALUE_W-1:0] v, logic h, logic e, logic l);
		result_t r;
		r.value        = v;
		r.half         = h;
		r.length_error = e;
		r.last_result  = l;
		expected_results.push_back(r);
	endfunction

	// predict the results of one accepted item and advance the run state
	task automatic predict_sample(input logic signed [SAMPLE_W-1:0] x, input logic lst);
		logic                      first;
		logic signed [VALUE_W-1:0] x64;
		logic signed [VALUE_W-1:0] prev64;
		logic signed [VALUE_W-1:0] lo64;
		logic signed [VALUE_W-1:0] hi64;
		logic signed [VALUE_W-1:0] sum2;
		logic signed [VALUE_W-1:0] org64;
		logic signed [VALUE_W-1:0] v;
		logic [VALUE_W-1:0]        acc_before;
		logic [VALUE_W-1:0]        acc_after;
		first      = (run_pos == '0);
		x64        = x;
		prev64     = prev_sample;
		org64      = cfg_origin;
		acc_before = run_sum;
		acc_after  = run_sum + x64;
		sum2       = x64 + prev64;

		// track extremes, keeping the first position of a tie
		if (first) begin
			low_val  = x;
			high_val = x;
			low_pos  = '0;
			high_pos = '0;
		end else if (x > high_val) begin
			high_val = x;
			high_pos = run_pos;
		end else if (x < low_val) begin
			low_val = x;
			low_pos = run_pos;
		end
		lo64 = low_val;
		hi64 = high_val;

		case (cfg_mode)
			MODE_MIN: if (lst) add_expect(lo64, 1'b0, 1'b0, 1'b1);
			MODE_MAX: if (lst) add_expect(hi64, 1'b0, 1'b0, 1'b1);
			MODE_ARGMIN: begin
				v = {48'b0, low_pos};
				if (lst) add_expect(v + org64, 1'b0, 1'b0, 1'b1);
			end
			MODE_ARGMAX: begin
				v = {48'b0, high_pos};
				if (lst) add_expect(v + org64, 1'b0, 1'b0, 1'b1);
			end
			MODE_PTP: begin
				v = (low_pos < high_pos) ? hi64 - lo64 : lo64 - hi64;
				if (lst) add_expect(v, 1'b0, 1'b0, 1'b1);
			end
			MODE_SUM:  if (lst) add_expect(acc_after, 1'b0, 1'b0, 1'b1);
			MODE_PSUM: add_expect(acc_after, 1'b0, 1'b0, lst);
			MODE_DIF: begin
				if (!first)
					add_expect(x64 - prev64, 1'b0, 1'b0, lst);
				else if (lst)
					add_expect('0, 1'b0, 1'b1, 1'b1);
			end
			MODE_CUM: begin
				add_expect(acc_before, 1'b0, 1'b0, 1'b0);
				if (lst) add_expect(acc_after, 1'b0, 1'b0, 1'b1);
			end
			MODE_ZCEN: begin
				if (!first)
					add_expect(sum2 >>> 1, sum2[0], 1'b0, lst);
				else if (lst)
					add_expect('0, 1'b0, 1'b1, 1'b1);
			end
			MODE_PCEN: begin
				if (first)
					add_expect(x64, 1'b0, 1'b0, 1'b0);
				else
					add_expect(sum2 >>> 1, sum2[0], 1'b0, 1'b0);
				if (lst) add_expect(x64, 1'b0, 1'b0, 1'b1);
			end
			MODE_UNCP: begin
				if (!first)
					add_expect(uncentre_val, 1'b0, 1'b0, lst);
				else if (lst)
					add_expect('0, 1'b0, 1'b1, 1'b1);
			end
			default: ;
		endcase

		// advance the run state; the index holds at its cap
		if (first)
			uncentre_val = x64;
		else
			uncentre_val = (x64 <<< 1) - uncentre_val;
		prev_sample = x;
		run_sum     = acc_after;
		if (run_pos < POS_CAP)
			run_pos = run_pos + 1'b1;
		if (lst) begin
			run_pos      = '0;
			run_sum      = '0;
			uncentre_val = '0;
		end
	endtask

	task automatic clear_model();
		cfg_mode     = MODE_RESET;
		cfg_origin   = ORIGIN_RESET;
		run_pos      = '0;
		run_sum      = '0;
		prev_sample  = '0;
		uncentre_val = '0;
		low_val      = '0;
		high_val     = '0;
		low_pos      = '0;
		high_pos     = '0;
	endtask

	// register write: setup cycle, then access cycle until pready
	task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_MODE)
			cfg_mode = data[MODE_W-1:0];
		else
			cfg_origin = data[ORIGIN_W-1:0];
	endtask

	task automatic set_config(input logic [MODE_W-1:0] m, input logic signed [ORIGIN_W-1:0] o);
		apb_write(REG_MODE, {28'b0, m});
		apb_write(REG_ORIGIN, {{16{o[15]}}, o});
		settings_used++;
	endtask

	task automatic push_item(input logic signed [SAMPLE_W-1:0] x, input logic lst);
		sample_item_t it;
		it.sample = x;
		it.last   = lst;
		pending_items.push_back(it);
	endtask

	task automatic push_run(input int unsigned len, input logic close);
		int unsigned i;
		for (i = 0; i < len; i++)
			push_item(rand_sample(), close && (i == len - 1));
	endtask

	// wait for every item to go in and every result to come out, then settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || samples.valid ||
			expected_results.size() != 0 || results.valid);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic note_mismatch(input string what, input result_t want,
		input logic [VALUE_W-1:0] v, input logic h, input logic e, input logic l);
		if (mismatches < 10)
			$display({"%0t %s: expected value=%0d half=%b err=%b last=%b, ",
				"got value=%0d half=%b err=%b last=%b"},
				$realtime, what, $signed(want.value), want.half, want.length_error,
				want.last_result, $signed(v), h, e, l);
		mismatches++;
	endtask

	// sample driver: present the oldest pending item, with random idle gaps between items
	always @(posedge clk) begin : drive_samples
		logic         nxt_valid;
		sample_item_t it;
		if (arst_n) begin
			nxt_valid = samples.valid;
			if (samples.valid && samples.ready) begin
				void'(pending_items.pop_front());
				nxt_valid = 1'b0;
				send_gap  = steady ? 0 : pick_gap();
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() > 0) begin
					it                  = pending_items[0];
					samples.sample      <= it.sample;
					samples.last_sample <= it.last;
					nxt_valid           = 1'b1;
				end
			end
			samples.valid <= nxt_valid;
		end
	end

	// accepted items feed the predictor
	always @(posedge clk) begin
		if (arst_n && samples.valid && samples.ready) begin
			modes_seen[cfg_mode] <= 1'b1;
			samples_taken++;
			if (samples.last_sample)
				runs_closed++;
			predict_sample(samples.sample, samples.last_sample);
		end
	end

	// result sink: stall at random unless in a steady stretch
	always @(posedge clk) begin
		if (arst_n) begin
			if (steady) begin
				results.ready <= 1'b1;
			end else if (stall_left > 0) begin
				results.ready <= 1'b0;
				stall_left--;
			end else begin
				results.ready <= 1'b1;
				if ($urandom_range(0, 99) < 20)
					stall_left = pick_gap();
			end
		end
	end

	// result checker: compare against the oldest expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && results.valid && results.ready) begin
			results_checked++;
			if (results.length_error)
				length_errors++;
			if (expected_results.size() == 0) begin
				want = '0;
				note_mismatch("result with none expected", want, results.value, results.half,
					results.length_error, results.last_result);
			end else begin
				want = expected_results.pop_front();
				if (results.value !== want.value || results.half !== want.half ||
					results.length_error !== want.length_error ||
					results.last_result !== want.last_result)
					note_mismatch("result mismatch", want, results.value, results.half,
						results.length_error, results.last_result);
			end
		end
	end

	// watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (samples.valid && samples.ready) || (results.valid && results.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no traffic for %0d cycles, %0d results outstanding",
					stall_cycles, expected_results.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int unsigned          r;
		int unsigned          n;
		int unsigned          k;
		int unsigned          random_items;
		int unsigned          phase_no;
		logic [MODE_W-1:0]    m;
		logic signed [15:0]   o;

		samples.valid       = 1'b0;
		samples.sample      = '0;
		samples.last_sample = 1'b0;
		results.ready       = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		steady              = 1'b0;
		send_gap            = 0;
		stall_left          = 0;
		stall_cycles        = 0;
		mismatches          = 0;
		samples_taken       = 0;
		results_checked     = 0;
		runs_closed         = 0;
		settings_used       = 0;
		length_errors       = 0;
		modes_seen          = '0;
		clear_model();

		// hold reset, then release it away from the rising edge
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, ties, single-element runs and an unknown mode
		set_config(MODE_MIN, 16'sd1);
		push_item(S_MAX, 1'b0);
		push_item(S_MIN, 1'b0);
		push_item(S_MIN, 1'b1);
		wait_idle();
		set_config(MODE_ARGMIN, ORIGIN_LOW);
		push_item(32'sd5, 1'b0);
		push_item(-32'sd3, 1'b0);
		push_item(-32'sd3, 1'b0);
		push_item(32'sd7, 1'b1);
		wait_idle();
		set_config(MODE_ARGMAX, ORIGIN_HIGH);
		push_item(32'sd9, 1'b0);
		push_item(32'sd9, 1'b1);
		wait_idle();
		set_config(MODE_PTP, 16'sd0);
		push_item(S_MIN, 1'b0);
		push_item(S_MAX, 1'b1);
		push_item(S_MAX, 1'b0);
		push_item(S_MIN, 1'b1);
		wait_idle();
		set_config(MODE_SUM, 16'sd0);
		push_item(S_MAX, 1'b0);
		push_item(S_MAX, 1'b1);
		wait_idle();
		set_config(MODE_DIF, 16'sd0);
		push_item(S_MIN, 1'b1);
		wait_idle();
		set_config(MODE_ZCEN, 16'sd0);
		push_item(32'sd3, 1'b1);
		push_item(S_MAX, 1'b0);
		push_item(S_MIN, 1'b1);
		wait_idle();
		set_config(MODE_UNCP, 16'sd0);
		push_item(-32'sd1, 1'b1);
		wait_idle();
		set_config(MODE_PCEN, 16'sd0);
		push_item(S_MAX, 1'b1);
		wait_idle();
		set_config(MODE_CUM, 16'sd0);
		push_item(S_MIN, 1'b1);
		wait_idle();
		set_config(MODE_UNKNOWN, 16'sd0);
		push_item(32'sd1, 1'b0);
		push_item(32'sd2, 1'b1);
		wait_idle();

		// random phases; some leave a run open across the next mode change
		random_items = 0;
		phase_no     = 0;
		while (random_items < ITEMS_RANDOM) begin
			r = $urandom_range(0, 99);
			if (r < 88)
				m = 4'($urandom_range(MODE_MIN, MODE_UNCP));
			else
				m = 4'($urandom_range(MODE_UNCP + 1, MODE_UNKNOWN));
			r = $urandom_range(0, 99);
			if (r < 10)
				o = ORIGIN_LOW;
			else if (r < 20)
				o = ORIGIN_HIGH;
			else if (r < 30)
				o = '0;
			else
				o = 16'($urandom);
			set_config(m, o);
			steady = (phase_no % 5 == 4);
			for (k = $urandom_range(2, 8); k > 0; k--) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					n = 1;
				else if (r < 70)
					n = $urandom_range(2, 6);
				else
					n = $urandom_range(7, 30);
				push_run(n, 1'b1);
				random_items += n;
			end
			if ($urandom_range(0, 99) < 30) begin
				n = $urandom_range(1, 4);
				push_run(n, 1'b0);
				random_items += n;
			end
			// hold further items back until every result is in
			wait_idle();
			phase_no++;
		end
		steady = 1'b0;
		wait_idle();

		$display("ran %0d samples in %0d closed runs over %0d settings; %0d results checked",
			samples_taken, runs_closed, settings_used, results_checked);
		$display("mode codes exercised %016b, length errors seen %0d, mismatches %0d",
			modes_seen, length_errors, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
